/* sv/sha384_pkg.sv */
`timescale 1ns / 1ps
// shared types, round constants and initial chaining values for the sha-384 engine
// used by sha384_sched, sha384_round and sha384_hash_engine; no dependencies
package sha384_pkg;

   localparam int unsigned NUM_ROUNDS   = 80;
   localparam int unsigned BLOCK_BYTES  = 128;
   localparam int unsigned LEN_POS      = 112;
   localparam int unsigned DIGEST_WORDS = 6;
   localparam int unsigned SCHED_DEPTH  = 16;

   typedef logic [63:0] word_type;
   typedef logic [DIGEST_WORDS-1:0][63:0] digest_type;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_PAD,
      ST_ROUND,
      ST_FINAL,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic       push;
      logic       word_end;
      logic [7:0] data;
      logic       step;
   } sched_ctl_type;

   typedef struct packed {
      logic init;
      logic start;
      logic step;
      logic finish;
   } round_ctl_type;

   localparam word_type IV [8] = '{
      64'hcbbb9d5dc1059ed8, 64'h629a292a367cd507, 64'h9159015a3070dd17, 64'h152fecd8f70e5939,
      64'h67332667ffc00b31, 64'h8eb44a8768581511, 64'hdb0c2e0d64f98fa7, 64'h47b5481dbefa4fa4
   };

   localparam word_type ROUND_K [NUM_ROUNDS] = '{
      64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
      64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
      64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
      64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
      64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
      64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
      64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
      64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
      64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
      64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
      64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
      64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
      64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
      64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
      64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
      64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
      64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
      64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
      64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
      64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
   };

   function automatic word_type rotr(input word_type x, input int unsigned n);
      return (x >> n) | (x << (64 - n));
   endfunction

endpackage

/* sv/sha384_sched.sv */
`timescale 1ns / 1ps
// message schedule: packs bytes into words and runs the 16-word schedule shift line
// depends on sha384_pkg
module sha384_sched (
   input  logic                      clock,
   input  sha384_pkg::sched_ctl_type ctl,
   output sha384_pkg::word_type      w_cur
);

   sha384_pkg::word_type line_ff [sha384_pkg::SCHED_DEPTH];
   sha384_pkg::word_type line_in [sha384_pkg::SCHED_DEPTH];
   logic [55:0]          acc_ff;
   logic [55:0]          acc_in;
   sha384_pkg::word_type sig0;
   sha384_pkg::word_type sig1;
   sha384_pkg::word_type next_word;
   logic                 shift;
   sha384_pkg::word_type shift_word;

   always_comb begin
      sig0 = sha384_pkg::rotr(line_ff[1], 1) ^ sha384_pkg::rotr(line_ff[1], 8)
           ^ (line_ff[1] >> 7);
      sig1 = sha384_pkg::rotr(line_ff[14], 19) ^ sha384_pkg::rotr(line_ff[14], 61)
           ^ (line_ff[14] >> 6);
      next_word = sig1 + line_ff[9] + sig0 + line_ff[0];
   end

   always_comb begin
      acc_in     = acc_ff;
      shift      = 1'b0;
      shift_word = next_word;
      if (ctl.push) begin
         if (ctl.word_end) begin
            shift      = 1'b1;
            shift_word = {acc_ff, ctl.data};
         end else begin
            acc_in = {acc_ff[47:0], ctl.data};
         end
      end else if (ctl.step) begin
         shift = 1'b1;
      end
      for (int i = 0; i < sha384_pkg::SCHED_DEPTH; i++) begin
         line_in[i] = line_ff[i];
      end
      if (shift) begin
         for (int i = 0; i < sha384_pkg::SCHED_DEPTH - 1; i++) begin
            line_in[i] = line_ff[i+1];
         end
         line_in[sha384_pkg::SCHED_DEPTH-1] = shift_word;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      line_ff <= line_in;
   end

   assign w_cur = line_ff[0];

endmodule

/* sv/sha384_round.sv */
`timescale 1ns / 1ps
// compression round unit: working variables, one sha-512 round per cycle while step is set, chaining words
// depends on sha384_pkg
module sha384_round (
   input  logic                      clock,
   input  logic                      reset,
   input  sha384_pkg::round_ctl_type ctl,
   input  logic [6:0]                rnd,
   input  sha384_pkg::word_type      w_cur,
   output sha384_pkg::digest_type    digest
);

   sha384_pkg::word_type chain_ff [8];
   sha384_pkg::word_type chain_in [8];
   sha384_pkg::word_type v_ff [8];
   sha384_pkg::word_type v_in [8];
   sha384_pkg::word_type big0;
   sha384_pkg::word_type big1;
   sha384_pkg::word_type choose;
   sha384_pkg::word_type major;
   sha384_pkg::word_type t1;
   sha384_pkg::word_type t2;

   always_comb begin
      big1   = sha384_pkg::rotr(v_ff[4], 14) ^ sha384_pkg::rotr(v_ff[4], 18)
             ^ sha384_pkg::rotr(v_ff[4], 41);
      choose = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
      t1     = v_ff[7] + big1 + choose + sha384_pkg::ROUND_K[rnd] + w_cur;
      big0   = sha384_pkg::rotr(v_ff[0], 28) ^ sha384_pkg::rotr(v_ff[0], 34)
             ^ sha384_pkg::rotr(v_ff[0], 39);
      major  = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
      t2     = big0 + major;
   end

   always_comb begin
      v_in     = v_ff;
      chain_in = chain_ff;
      if (ctl.start) begin
         v_in = chain_ff;
      end else if (ctl.step) begin
         v_in[7] = v_ff[6];
         v_in[6] = v_ff[5];
         v_in[5] = v_ff[4];
         v_in[4] = v_ff[3] + t1;
         v_in[3] = v_ff[2];
         v_in[2] = v_ff[1];
         v_in[1] = v_ff[0];
         v_in[0] = t1 + t2;
      end
      if (ctl.init) begin
         chain_in = sha384_pkg::IV;
      end else if (ctl.finish) begin
         for (int i = 0; i < 8; i++) begin
            chain_in[i] = chain_ff[i] + v_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff <= sha384_pkg::IV;
      end else begin
         chain_ff <= chain_in;
      end
      v_ff <= v_in;
   end

   always_comb begin
      for (int i = 0; i < sha384_pkg::DIGEST_WORDS; i++) begin
         digest[i] = chain_ff[i];
      end
   end

endmodule

/* sv/sha384_hash_engine.sv */
`timescale 1ns / 1ps
// sha-384 hash engine top level: sequencer, byte counter, padding and digest output
// depends on sha384_pkg, sha384_sched and sha384_round
//
// usage
//   req channel: one word per accepted item: a message byte (req_byte_valid) and/or
//   the end mark (req_end_of_message); an item with neither flag is a no-op
//   rsp channel: six 64-bit digest words per message, index 0..5, last flag on 5
//   the byte that fills a 128-byte block starts its compression: 80 rounds on the
//   shared round unit, then one feed-forward add, while requests are stalled
//   after the end mark, padding and length go through the same byte path one byte a
//   cycle up to each block end, then each padded block (one or two) is compressed,
//   then the first digest word is loaded into the output register, then the six
//   digest words, one per cycle when not stalled
//   req_stall is high while a block is compressed and from the end mark until the
//   last digest word is taken
//   while rsp_stall is high the current digest word holds and the engine waits
//   reset (synchronous) loads the initial chaining values and clears the counters;
//   after the last digest word the engine returns to the same state
module sha384_hash_engine (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_byte_valid,
   input  logic        req_end_of_message,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);

   sha384_pkg::state_type     state_ff;
   sha384_pkg::state_type     state_in;
   logic [6:0]                fill_ff;
   logic [6:0]                fill_in;
   logic [63:0]               count_ff;
   logic [63:0]               count_in;
   logic [127:0]              len_ff;
   logic [127:0]              len_in;
   logic                      pend_end_ff;
   logic                      pend_end_in;
   logic                      mark_ff;
   logic                      mark_in;
   logic                      len_ok_ff;
   logic                      len_ok_in;
   logic                      last_blk_ff;
   logic                      last_blk_in;
   logic [6:0]                rnd_ff;
   logic [6:0]                rnd_in;
   logic [2:0]                idx_ff;
   logic [2:0]                idx_in;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   sha384_pkg::word_type      rsp_word_ff;
   sha384_pkg::word_type      rsp_word_in;

   logic                      req_acc;
   logic                      push;
   logic [7:0]                push_data;
   logic                      blk_full;
   logic                      len_byte;
   logic                      rsp_done;
   logic [2:0]                idx_next;
   sha384_pkg::sched_ctl_type sched_ctl;
   sha384_pkg::round_ctl_type round_ctl;
   sha384_pkg::word_type      w_cur;
   sha384_pkg::digest_type    digest;

   sha384_sched u_sched (
      .clock (clock),
      .ctl   (sched_ctl),
      .w_cur (w_cur)
   );

   sha384_round u_round (
      .clock  (clock),
      .reset  (reset),
      .ctl    (round_ctl),
      .rnd    (rnd_ff),
      .w_cur  (w_cur),
      .digest (digest)
   );

   assign req_acc  = req_valid && !req_stall;
   assign len_byte = len_ok_ff && (fill_ff >= 7'(sha384_pkg::LEN_POS));
   assign blk_full = push && (fill_ff == 7'(sha384_pkg::BLOCK_BYTES - 1));
   assign rsp_done = (state_ff == sha384_pkg::ST_OUT) && rsp_valid_ff && !rsp_stall
                     && (idx_ff == 3'(sha384_pkg::DIGEST_WORDS - 1));
   assign idx_next = idx_ff + 3'd1;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sha384_pkg::ST_LOAD: begin
            if (req_acc) begin
               if (blk_full) begin
                  state_in = sha384_pkg::ST_ROUND;
               end else if (req_end_of_message) begin
                  state_in = sha384_pkg::ST_PAD;
               end
            end
         end
         sha384_pkg::ST_PAD: begin
            if (blk_full) begin
               state_in = sha384_pkg::ST_ROUND;
            end
         end
         sha384_pkg::ST_ROUND: begin
            if (rnd_ff == 7'(sha384_pkg::NUM_ROUNDS - 1)) begin
               state_in = sha384_pkg::ST_FINAL;
            end
         end
         sha384_pkg::ST_FINAL: begin
            if (last_blk_ff) begin
               state_in = sha384_pkg::ST_OUT;
            end else if (pend_end_ff) begin
               state_in = sha384_pkg::ST_PAD;
            end else begin
               state_in = sha384_pkg::ST_LOAD;
            end
         end
         sha384_pkg::ST_OUT: begin
            if (rsp_done) begin
               state_in = sha384_pkg::ST_LOAD;
            end
         end
         default: state_in = sha384_pkg::ST_LOAD;
      endcase
   end

   // state outputs
   always_comb begin
      req_stall = 1'b1;
      push      = 1'b0;
      push_data = req_data_byte;
      unique case (state_ff)
         sha384_pkg::ST_LOAD: begin
            req_stall = 1'b0;
            push      = req_valid && req_byte_valid;
         end
         sha384_pkg::ST_PAD: begin
            push = 1'b1;
            if (mark_ff) begin
               push_data = 8'h80;
            end else if (len_byte) begin
               push_data = len_ff[127:120];
            end else begin
               push_data = 8'h00;
            end
         end
         sha384_pkg::ST_ROUND, sha384_pkg::ST_FINAL, sha384_pkg::ST_OUT: begin
            push = 1'b0;
         end
         default: push = 1'b0;
      endcase
      sched_ctl.push     = push;
      sched_ctl.word_end = (fill_ff[2:0] == 3'b111);
      sched_ctl.data     = push_data;
      sched_ctl.step     = (state_ff == sha384_pkg::ST_ROUND);
      round_ctl.init     = rsp_done;
      round_ctl.start    = blk_full;
      round_ctl.step     = (state_ff == sha384_pkg::ST_ROUND);
      round_ctl.finish   = (state_ff == sha384_pkg::ST_FINAL);
   end

   // datapath and flag registers
   always_comb begin
      fill_in      = push ? fill_ff + 7'd1 : fill_ff;
      count_in     = count_ff;
      len_in       = len_ff;
      pend_end_in  = pend_end_ff;
      mark_in      = mark_ff;
      len_ok_in    = len_ok_ff;
      last_blk_in  = last_blk_ff;
      rnd_in       = (state_ff == sha384_pkg::ST_ROUND) ? rnd_ff + 7'd1 : 7'd0;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;

      if (state_ff == sha384_pkg::ST_LOAD && req_acc) begin
         if (req_byte_valid) begin
            count_in = count_ff + 64'd1;
         end
         if (req_end_of_message) begin
            pend_end_in = 1'b1;
            mark_in     = 1'b1;
            len_in      = {61'd0, count_ff + 64'(req_byte_valid), 3'd0};
         end
      end

      if (state_ff == sha384_pkg::ST_PAD) begin
         mark_in = 1'b0;
         if (fill_ff == 7'(sha384_pkg::BLOCK_BYTES - 1)) begin
            last_blk_in = len_ok_ff && !mark_ff;
            len_ok_in   = 1'b1;
         end else if (mark_ff) begin
            len_ok_in = (fill_ff < 7'(sha384_pkg::LEN_POS));
         end
         if (!mark_ff && len_byte) begin
            len_in = {len_ff[119:0], 8'd0};
         end
      end

      if (state_ff == sha384_pkg::ST_FINAL) begin
         idx_in = 3'd0;
      end

      if (state_ff == sha384_pkg::ST_OUT) begin
         if (!rsp_valid_ff) begin
            rsp_valid_in = 1'b1;
            rsp_word_in  = digest[idx_ff];
         end else if (!rsp_stall) begin
            if (rsp_done) begin
               rsp_valid_in = 1'b0;
            end else begin
               idx_in      = idx_next;
               rsp_word_in = digest[idx_next];
            end
         end
      end

      if (rsp_done) begin
         count_in    = 64'd0;
         pend_end_in = 1'b0;
         len_ok_in   = 1'b0;
         last_blk_in = 1'b0;
         idx_in      = 3'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sha384_pkg::ST_LOAD;
         fill_ff      <= 7'd0;
         count_ff     <= 64'd0;
         pend_end_ff  <= 1'b0;
         mark_ff      <= 1'b0;
         len_ok_ff    <= 1'b0;
         last_blk_ff  <= 1'b0;
         rnd_ff       <= 7'd0;
         idx_ff       <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         count_ff     <= count_in;
         pend_end_ff  <= pend_end_in;
         mark_ff      <= mark_in;
         len_ok_ff    <= len_ok_in;
         last_blk_ff  <= last_blk_in;
         rnd_ff       <= rnd_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      len_ff      <= len_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_digest_word = rsp_word_ff;
   assign rsp_word_index  = idx_ff;
   assign rsp_last_word   = (idx_ff == 3'(sha384_pkg::DIGEST_WORDS - 1));

`ifndef SYNTHESIS
   a_rsp_only_in_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> state_ff == sha384_pkg::ST_OUT)
      else $error("digest word shown outside the output phase");

   a_round_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sha384_pkg::ST_ROUND && rnd_ff == 7'(sha384_pkg::NUM_ROUNDS - 1))
      |=> state_ff == sha384_pkg::ST_FINAL)
      else $error("compression did not end after the last round");

   a_clean_restart: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_last_word)
      |=> (state_ff == sha384_pkg::ST_LOAD && fill_ff == 7'd0 && count_ff == 64'd0))
      else $error("engine not back to an empty message after the last digest word");

   a_no_input_when_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sha384_pkg::ST_PAD || state_ff == sha384_pkg::ST_ROUND) |-> req_stall)
      else $error("input taken while a block is being processed");
`endif

endmodule

/* tb/sha384_hash_engine_test.sv */
`timescale 1ns / 1ps
// self-checking testbench for sha384_hash_engine: directed table, then random messages
// depends on sha384_pkg and the engine rtl; digests are predicted by an in-bench sha-384 model
module sha384_hash_engine_test;

   localparam int IDLE_LIMIT = 4000;
   localparam int TAIL_CYCLES = 400;
   localparam int ITEM_TARGET = 310;
   localparam int MIN_MESSAGES = 8;
   localparam int HOLD_AFTER_WORDS = 18;
   localparam int HOLD_CYCLES = 400;
   localparam int DIR_ROWS = 17;

   localparam logic [383:0] EMPTY_DIGEST = {
      64'h38b060a751ac9638, 64'h4cd9327eb1b1e36a, 64'h21fdb71114be0743,
      64'h4c0cc7bf63f6e1da, 64'h274edebfe76f65fb, 64'hd51ad2f14898b95b
   };

   localparam sha384_pkg::word_type INIT_CHAIN [8] = '{
      64'hcbbb9d5dc1059ed8, 64'h629a292a367cd507, 64'h9159015a3070dd17, 64'h152fecd8f70e5939,
      64'h67332667ffc00b31, 64'h8eb44a8768581511, 64'hdb0c2e0d64f98fa7, 64'h47b5481dbefa4fa4
   };

   localparam sha384_pkg::word_type RK [80] = '{
      64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
      64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
      64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
      64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
      64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
      64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
      64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
      64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
      64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
      64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
      64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
      64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
      64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
      64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
      64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
      64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
      64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
      64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
      64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
      64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
   };

   typedef struct packed {
      logic [7:0] data;
      logic       byte_valid;
      logic       end_mark;
      logic       typed;
   } dir_row_type;

   // typed rows expect the digest of the empty message
   localparam dir_row_type DIR_TABLE [DIR_ROWS] = '{
      '{8'h00, 1'b0, 1'b1, 1'b1},
      '{8'h5a, 1'b0, 1'b0, 1'b0},
      '{8'ha5, 1'b0, 1'b1, 1'b1},
      '{8'h00, 1'b1, 1'b1, 1'b0},
      '{8'hff, 1'b1, 1'b1, 1'b0},
      '{8'h61, 1'b1, 1'b0, 1'b0},
      '{8'h62, 1'b1, 1'b0, 1'b0},
      '{8'hff, 1'b0, 1'b0, 1'b0},
      '{8'h63, 1'b1, 1'b0, 1'b0},
      '{8'h00, 1'b0, 1'b1, 1'b0},
      '{8'hff, 1'b1, 1'b0, 1'b0},
      '{8'h00, 1'b1, 1'b0, 1'b0},
      '{8'h80, 1'b1, 1'b0, 1'b0},
      '{8'h7f, 1'b1, 1'b1, 1'b0},
      '{8'h55, 1'b1, 1'b0, 1'b0},
      '{8'haa, 1'b1, 1'b1, 1'b0},
      '{8'hff, 1'b0, 1'b1, 1'b1}
   };

   typedef struct {
      sha384_pkg::word_type word;
      logic [2:0]           index;
      logic                 last;
   } digest_word_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_byte_valid = 1'b0;
   logic        req_end_of_message = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [63:0] rsp_digest_word;
   logic [2:0]  rsp_word_index;
   logic        rsp_last_word;

   sha384_pkg::word_type chain [8];
   logic [7:0]           block_buf [sha384_pkg::BLOCK_BYTES];
   int unsigned          fill_count;
   logic [63:0]          msg_byte_count;
   digest_word_type      digest_words_due [$];
   digest_word_type      due_word;
   int                   mismatch_count = 0;
   int                   words_taken = 0;
   int                   items_sent = 0;
   int                   messages_sent = 0;
   int                   idle_cycles = 0;
   logic                 tight_burst = 1'b0;
   logic                 hold_done = 1'b0;

   sha384_hash_engine u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .req_byte_valid     (req_byte_valid),
      .req_end_of_message (req_end_of_message),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_digest_word    (rsp_digest_word),
      .rsp_word_index     (rsp_word_index),
      .rsp_last_word      (rsp_last_word)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic sha384_pkg::word_type ror64(input sha384_pkg::word_type x,
                                                  input int unsigned n);
      return (x >> n) | (x << (64 - n));
   endfunction

   function automatic void hash_state_clear();
      for (int i = 0; i < 8; i++) chain[i] = INIT_CHAIN[i];
      fill_count = 0;
      msg_byte_count = '0;
   endfunction

   function automatic void sha512_compress_buf();
      sha384_pkg::word_type w [80];
      sha384_pkg::word_type v [8];
      sha384_pkg::word_type s0, s1, t1, t2;
      for (int i = 0; i < 16; i++) begin
         w[i] = '0;
         for (int j = 0; j < 8; j++) w[i] = {w[i][55:0], block_buf[i * 8 + j]};
      end
      for (int i = 16; i < 80; i++) begin
         s0 = ror64(w[i-15], 1) ^ ror64(w[i-15], 8) ^ (w[i-15] >> 7);
         s1 = ror64(w[i-2], 19) ^ ror64(w[i-2], 61) ^ (w[i-2] >> 6);
         w[i] = s1 + w[i-7] + s0 + w[i-16];
      end
      for (int i = 0; i < 8; i++) v[i] = chain[i];
      for (int i = 0; i < 80; i++) begin
         t1 = v[7] + (ror64(v[4], 14) ^ ror64(v[4], 18) ^ ror64(v[4], 41))
            + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RK[i] + w[i];
         t2 = (ror64(v[0], 28) ^ ror64(v[0], 34) ^ ror64(v[0], 39))
            + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6];
         v[6] = v[5];
         v[5] = v[4];
         v[4] = v[3] + t1;
         v[3] = v[2];
         v[2] = v[1];
         v[1] = v[0];
         v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) chain[i] = chain[i] + v[i];
   endfunction

   // returns 1 when the item closes a message, with its digest in dg
   function automatic logic sha384_absorb(input logic [7:0] d, input logic bv, input logic eom,
                                          output logic [383:0] dg);
      logic [127:0] bit_len;
      dg = '0;
      if (bv) begin
         block_buf[fill_count] = d;
         fill_count++;
         msg_byte_count++;
         if (fill_count == sha384_pkg::BLOCK_BYTES) begin
            sha512_compress_buf();
            fill_count = 0;
         end
      end
      if (!eom) return 1'b0;
      bit_len = {61'd0, msg_byte_count, 3'd0};
      block_buf[fill_count] = 8'h80;
      fill_count++;
      if (fill_count > sha384_pkg::LEN_POS) begin
         for (int i = fill_count; i < sha384_pkg::BLOCK_BYTES; i++) block_buf[i] = 8'h00;
         sha512_compress_buf();
         fill_count = 0;
      end
      for (int i = fill_count; i < sha384_pkg::LEN_POS; i++) block_buf[i] = 8'h00;
      for (int i = 0; i < 16; i++)
         block_buf[sha384_pkg::LEN_POS + i] = bit_len[127 - 8 * i -: 8];
      sha512_compress_buf();
      for (int i = 0; i < sha384_pkg::DIGEST_WORDS; i++) dg[383 - 64 * i -: 64] = chain[i];
      hash_state_clear();
      return 1'b1;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (tight_burst || r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic void note_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10) $display("%s", msg);
   endfunction

   task automatic send_item(input logic [7:0] d, input logic bv, input logic eom,
                            input logic typed);
      int gap;
      logic closes;
      logic [383:0] dg;
      digest_word_type e;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= d;
      req_byte_valid <= bv;
      req_end_of_message <= eom;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (bv || eom) items_sent++;
      closes = sha384_absorb(d, bv, eom, dg);
      if (closes) begin
         messages_sent++;
         if (typed) dg = EMPTY_DIGEST;
         for (int i = 0; i < sha384_pkg::DIGEST_WORDS; i++) begin
            e.word = dg[383 - 64 * i -: 64];
            e.index = 3'(i);
            e.last = (i == sha384_pkg::DIGEST_WORDS - 1);
            digest_words_due.push_back(e);
         end
      end
   endtask

   initial begin : stimulus
      int len, r;
      hash_state_clear();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < DIR_ROWS; i++)
         send_item(DIR_TABLE[i].data, DIR_TABLE[i].byte_valid, DIR_TABLE[i].end_mark,
                   DIR_TABLE[i].typed);

      while (items_sent < ITEM_TARGET || messages_sent < MIN_MESSAGES) begin
         tight_burst = ($urandom_range(0, 3) == 0);
         r = $urandom_range(0, 99);
         if (r < 65) len = $urandom_range(0, 10);
         else if (r < 85) len = $urandom_range(105, 130);
         else if (r < 90) len = $urandom_range(230, 260);
         else len = $urandom_range(11, 60);
         if (items_sent < ITEM_TARGET && len > ITEM_TARGET - items_sent)
            len = ITEM_TARGET - items_sent;
         for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 9) == 0)
               send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0);
            send_item(8'($urandom_range(0, 255)), 1'b1,
                      (k == len - 1) && (len[0] == 1'b1), 1'b0);
         end
         // odd lengths end on the last byte, others on a separate marker
         if (len == 0 || len[0] == 1'b0)
            send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0);
      end
      tight_burst = 1'b0;
      req_valid <= 1'b0;

      while (digest_words_due.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && digest_words_due.size() == 0) begin
         $display("PASS sha384_hash_engine");
      end else begin
         $display("FAIL sha384_hash_engine");
      end
      $finish;
   end

   initial begin : rsp_pacer
      int free_len, stall_len;
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 99) < 80) free_len = $urandom_range(1, 8);
         else free_len = $urandom_range(50, 200);
         rsp_stall <= 1'b0;
         repeat (free_len) @(posedge clock);
         // one long hold-off so the engine backs up into the request side
         if (!hold_done && words_taken >= HOLD_AFTER_WORDS) begin
            hold_done = 1'b1;
            stall_len = HOLD_CYCLES;
         end else begin
            stall_len = pick_gap();
         end
         if (stall_len > 0) begin
            rsp_stall <= 1'b1;
            repeat (stall_len) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         words_taken++;
         if (digest_words_due.size() == 0) begin
            note_mismatch($sformatf("unexpected digest word %h index %0d last %b",
                                    rsp_digest_word, rsp_word_index, rsp_last_word));
         end else begin
            due_word = digest_words_due.pop_front();
            if (rsp_digest_word !== due_word.word || rsp_word_index !== due_word.index ||
                rsp_last_word !== due_word.last)
               note_mismatch($sformatf(
                  "digest mismatch: exp %h idx %0d last %b, got %h idx %0d last %b",
                  due_word.word, due_word.index, due_word.last,
                  rsp_digest_word, rsp_word_index, rsp_last_word));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAIL sha384_hash_engine");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
